@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence on every rising clk edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence on the next rising clk edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ptcr_pkg.sv @@
// Shared types and constants of the page translation block.
package ptcr_pkg;

	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_HIT      = 3'd1;
	localparam logic [2:0] ST_FAULT    = 3'd2;
	localparam logic [2:0] ST_SEGV     = 3'd3;
	localparam logic [2:0] ST_NOVICTIM = 3'd4;
	localparam logic [2:0] ST_RANGE    = 3'd5;

	localparam logic REG_PAGE_OFFSET_BITS = 1'b0;
	localparam logic REG_VIRT_ADDR_BITS   = 1'b1;

	localparam logic [3:0] OFFSET_BITS_RESET = 4'd8;
	localparam logic [4:0] VADDR_BITS_RESET  = 5'd16;

	typedef struct packed {
		logic       cap;
		logic       clr_wr;
		logic       load_wr;
		logic       rd_pg;
		logic       rd_hand;
		logic       wr_use;
		logic       hand_init;
		logic       step;
		logic       wr_new;
		logic       set_res;
		logic [2:0] res_status;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_translate;
		logic load_ok;
		logic in_range;
		logic ent_valid;
		logic ent_perm;
		logic ent_use;
		logic sweep_last;
	} dp_stat_t;

endpackage

@@ rtl/page_translate_clock_replace.sv @@
// Top level of the page translation block with clock page replacement.
// Input channel (in_valid/in_ready) carries one word per item: a table load
// (operation 0) or a translate of virt_addr (operation 1). Output channel
// (out_valid/out_ready) returns one word per item with status and phys_addr.
// Registers page_offset_bits and virt_addr_bits are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. After reset the table is
// cleared one entry per cycle with in_ready low; configuration writes are
// taken during that time. From acceptance, a load or an out of range page
// passes the states S_EXEC and S_FIN, and a hit or a segfault S_EXEC, S_TR_CHK
// and S_FIN. A fault walks the clock hand with one read of the table memory
// per entry and an update of each valid entry it visits, at most twice the
// page count, and writes the new entry in S_F_WR when a victim is found. One
// item is in work at a time; the next can be accepted once its result has
// entered the output register.
// A finished result waits in the output register while the receiver stalls;
// the block meanwhile accepts and works on the next word, and holds its own
// result until the output register frees.
`include "assert_macros.svh"

module page_translate_clock_replace #(
	parameter int MAX_PAGES   = 256,
	parameter int FRAME_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  page_index,
	input  logic [15:0] virt_addr,
	input  logic        entry_valid,
	input  logic        entry_perm,
	input  logic [15:0] entry_frame,
	input  logic        entry_use,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [30:0] phys_addr
);

	ptcr_pkg::dp_cmd_t  cmd;
	ptcr_pkg::dp_stat_t stat;
	logic               in_acc;
	logic [6:0]         mem_ops;

	assign in_acc  = in_valid & in_ready;
	assign mem_ops = {cmd.clr_wr, cmd.load_wr, cmd.rd_pg, cmd.rd_hand,
		cmd.wr_use, cmd.step, cmd.wr_new};

	ptcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ptcr_dp #(
		.MAX_PAGES   (MAX_PAGES),
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.page_index  (page_index),
		.virt_addr   (virt_addr),
		.entry_valid (entry_valid),
		.entry_perm  (entry_perm),
		.entry_frame (entry_frame),
		.entry_use   (entry_use),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.phys_addr   (phys_addr)
	);

	`ASSERT_CLK(a_one_mem_op, $countones(mem_ops) <= 1, "more than one table access")
	`ASSERT_IMPL(a_no_load_on_accept, in_acc, !cmd.out_load && !cmd.set_res, "result on accept")
	`ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "ready held after an accepted word")
	`ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid, "loaded result not shown")

endmodule

@@ rtl/ptcr_dp.sv @@
// Datapath: page table memory, clock hand, configuration and result registers.
module ptcr_dp #(
	parameter int MAX_PAGES   = 256,
	parameter int FRAME_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [4:0]           cfg_data,
	input  logic                 operation,
	input  logic [7:0]           page_index,
	input  logic [15:0]          virt_addr,
	input  logic                 entry_valid,
	input  logic                 entry_perm,
	input  logic [15:0]          entry_frame,
	input  logic                 entry_use,
	input  ptcr_pkg::dp_cmd_t    cmd,
	output ptcr_pkg::dp_stat_t   stat,
	output logic [2:0]           status,
	output logic [30:0]          phys_addr
);

	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int SW = CW + 1;
	localparam int EW = FRAME_WIDTH + 3;
	localparam logic [16:0] MAXP = 17'(MAX_PAGES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAGES - 1);

	logic [EW-1:0] mem [MAX_PAGES];
	logic [EW-1:0] mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic [3:0]  ob_q;
	logic [4:0]  vab_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] hand_q;
	logic [SW-1:0] steps_q;

	logic                   op_q;
	logic [7:0]             idx_q;
	logic [15:0]            addr_q;
	logic                   ev_q;
	logic                   ep_q;
	logic [FRAME_WIDTH-1:0] ef_q;
	logic                   eu_q;
	logic [FRAME_WIDTH-1:0] vic_q;

	logic [2:0]  res_status_q;
	logic [30:0] res_phys_q;
	logic [2:0]  status_q;
	logic [30:0] phys_q;

	logic [15:0] pg;
	logic [15:0] off;
	logic [AW-1:0] pg_a;
	logic [AW-1:0] idx_a;
	logic [16:0] idx17;
	logic [16:0] pg17;
	logic        under;
	logic [4:0]  dsh;
	logic [16:0] pow17;
	logic [16:0] count_full;
	logic [CW-1:0] count;
	logic [CW-1:0] hand_ext;
	logic [CW-1:0] hand_inc;
	logic [AW-1:0] hand_next;
	logic [SW-1:0] steps_inc;
	logic        r_valid;
	logic        r_perm;
	logic        r_use;
	logic [FRAME_WIDTH-1:0] r_frame;
	logic [FRAME_WIDTH-1:0] frame_src;
	logic [30:0] phys;

	assign pg    = addr_q >> ob_q;
	assign off   = addr_q & ~(16'hFFFF << ob_q);
	assign pg17  = {1'b0, pg};
	assign idx17 = {9'b0, idx_q};
	assign pg_a  = pg17[AW-1:0];
	assign idx_a = idx17[AW-1:0];

	assign under = vab_q < {1'b0, ob_q};
	assign dsh   = vab_q - {1'b0, ob_q};
	assign pow17 = 17'd1 << dsh;

	always_comb begin
		if (under) begin
			count_full = 17'd0;
		end else if (dsh >= 5'd17 || pow17 > MAXP) begin
			count_full = MAXP;
		end else begin
			count_full = pow17;
		end
	end

	assign count     = count_full[CW-1:0];
	assign hand_ext  = CW'(hand_q);
	assign hand_inc  = hand_ext + CW'(1);
	assign hand_next = (hand_inc >= count) ? '0 : hand_inc[AW-1:0];
	assign steps_inc = steps_q + SW'(1);

	assign r_valid = mem_rdata_q[EW-1];
	assign r_perm  = mem_rdata_q[EW-2];
	assign r_use   = mem_rdata_q[EW-3];
	assign r_frame = mem_rdata_q[FRAME_WIDTH-1:0];

	assign frame_src = (cmd.res_status == ptcr_pkg::ST_FAULT) ? vic_q : r_frame;
	assign phys      = (31'(frame_src) << ob_q) | {15'b0, off};

	assign stat.clr_done     = clr_q == LAST_ADDR;
	assign stat.is_translate = op_q;
	assign stat.load_ok      = idx17 < MAXP;
	assign stat.in_range     = pg17 < count_full;
	assign stat.ent_valid    = r_valid;
	assign stat.ent_perm     = r_perm;
	assign stat.ent_use      = r_use;
	assign stat.sweep_last   = steps_inc == {count, 1'b0};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pg_a;
		mem_wdata = mem_rdata_q;
		if (cmd.clr_wr) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (cmd.load_wr) begin
			mem_we    = 1'b1;
			mem_waddr = idx_a;
			mem_wdata = {ev_q, ep_q, eu_q, ef_q};
		end else if (cmd.wr_use) begin
			mem_we    = 1'b1;
			mem_waddr = pg_a;
			mem_wdata = {r_valid, r_perm, 1'b1, r_frame};
		end else if (cmd.step && r_valid) begin
			mem_we    = 1'b1;
			mem_waddr = hand_q;
			if (r_use) begin
				mem_wdata = {r_valid, r_perm, 1'b0, r_frame};
			end else begin
				mem_wdata = {1'b0, r_perm, r_use, r_frame};
			end
		end else if (cmd.wr_new) begin
			mem_we    = 1'b1;
			mem_waddr = pg_a;
			mem_wdata = {1'b1, 1'b1, 1'b1, vic_q};
		end
	end

	assign mem_re    = cmd.rd_pg | cmd.rd_hand;
	assign mem_raddr = cmd.rd_hand ? hand_q : pg_a;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_q    <= ptcr_pkg::OFFSET_BITS_RESET;
			vab_q   <= ptcr_pkg::VADDR_BITS_RESET;
			clr_q   <= '0;
			hand_q  <= '0;
			steps_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptcr_pkg::REG_PAGE_OFFSET_BITS: ob_q  <= cfg_data[3:0];
					ptcr_pkg::REG_VIRT_ADDR_BITS:   vab_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.hand_init) begin
				steps_q <= '0;
				if (hand_ext >= count) begin
					hand_q <= '0;
				end
			end else if (cmd.step) begin
				steps_q <= steps_inc;
				hand_q  <= hand_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= operation;
			idx_q  <= page_index;
			addr_q <= virt_addr;
			ev_q   <= entry_valid;
			ep_q   <= entry_perm;
			ef_q   <= entry_frame[FRAME_WIDTH-1:0];
			eu_q   <= entry_use;
		end
		if (cmd.step) begin
			vic_q <= r_frame;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			if (cmd.res_status == ptcr_pkg::ST_HIT || cmd.res_status == ptcr_pkg::ST_FAULT) begin
				res_phys_q <= phys;
			end else begin
				res_phys_q <= '0;
			end
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			phys_q   <= res_phys_q;
		end
	end

	assign status    = status_q;
	assign phys_addr = phys_q;

endmodule

@@ rtl/ptcr_ctrl.sv @@
// Controller state machine that sequences loads, lookups and clock sweeps.
module ptcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ptcr_pkg::dp_stat_t  stat,
	output ptcr_pkg::dp_cmd_t   cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_TR_CHK = 3'd3;
	localparam logic [2:0] S_F_RD   = 3'd4;
	localparam logic [2:0] S_F_CHK  = 3'd5;
	localparam logic [2:0] S_F_WR   = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.is_translate) begin
					cmd.set_res = 1'b1;
					if (stat.load_ok) begin
						cmd.load_wr    = 1'b1;
						cmd.res_status = ptcr_pkg::ST_LOADED;
					end else begin
						cmd.res_status = ptcr_pkg::ST_RANGE;
					end
					state_d = S_FIN;
				end else if (!stat.in_range) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ptcr_pkg::ST_RANGE;
					state_d        = S_FIN;
				end else begin
					cmd.rd_pg = 1'b1;
					state_d   = S_TR_CHK;
				end
			end
			S_TR_CHK: begin
				if (stat.ent_valid) begin
					cmd.wr_use     = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ptcr_pkg::ST_HIT;
					state_d        = S_FIN;
				end else if (stat.ent_perm) begin
					cmd.hand_init = 1'b1;
					state_d       = S_F_RD;
				end else begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ptcr_pkg::ST_SEGV;
					state_d        = S_FIN;
				end
			end
			S_F_RD: begin
				cmd.rd_hand = 1'b1;
				state_d     = S_F_CHK;
			end
			S_F_CHK: begin
				cmd.step = 1'b1;
				if (stat.ent_valid && !stat.ent_use) begin
					state_d = S_F_WR;
				end else if (stat.sweep_last) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ptcr_pkg::ST_NOVICTIM;
					state_d        = S_FIN;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_WR: begin
				cmd.wr_new     = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ptcr_pkg::ST_FAULT;
				state_d        = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the page translation block with clock page replacement.
module testbench;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_XLATE = 1'b1;
	localparam int TABLE_DEPTH = 256;
	localparam int LIMIT_CYCLES = 4000000;
	localparam int TAIL_CYCLES = 64;
	localparam int SEGMENTS = 5;
	localparam int WORDS_PER_SEGMENT = 50;

	typedef struct {
		logic        op;
		logic [7:0]  idx;
		logic [15:0] addr;
		logic        v;
		logic        p;
		logic [15:0] f;
		logic        u;
	} table_word_t;

	typedef struct {
		logic [2:0]  status;
		logic [30:0] phys;
	} xlate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = 5'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [7:0]  page_index = 8'd0;
	logic [15:0] virt_addr = 16'd0;
	logic        entry_valid = 1'b0;
	logic        entry_perm = 1'b0;
	logic [15:0] entry_frame = 16'd0;
	logic        entry_use = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [30:0] phys_addr;

	logic        tbl_valid [TABLE_DEPTH];
	logic        tbl_perm [TABLE_DEPTH];
	logic [15:0] tbl_frame [TABLE_DEPTH];
	logic        tbl_use [TABLE_DEPTH];
	int unsigned clock_hand = 0;
	logic [3:0]  offset_bits = ptcr_pkg::OFFSET_BITS_RESET;
	logic [4:0]  vaddr_bits = ptcr_pkg::VADDR_BITS_RESET;

	xlate_t pending_results [$];
	int mismatches = 0;
	int send_idle = 34;
	int recv_idle = 60;
	int cycles = 0;

	page_translate_clock_replace dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.page_index(page_index),
		.virt_addr(virt_addr),
		.entry_valid(entry_valid),
		.entry_perm(entry_perm),
		.entry_frame(entry_frame),
		.entry_use(entry_use),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.phys_addr(phys_addr)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	function automatic int unsigned page_count();
		int unsigned d;
		if (vaddr_bits < offset_bits)
			return 0;
		d = vaddr_bits - offset_bits;
		if (d >= 8)
			return TABLE_DEPTH;
		return 1 << d;
	endfunction

	function automatic logic clock_evict(int unsigned pg, int unsigned count);
		int unsigned h;
		logic victim;
		if (clock_hand >= count)
			clock_hand = 0;
		for (int unsigned s = 0; s < 2 * count; s++) begin
			h = clock_hand;
			victim = 1'b0;
			if (tbl_valid[h]) begin
				if (tbl_use[h])
					tbl_use[h] = 1'b0;
				else
					victim = 1'b1;
			end
			if (victim) begin
				tbl_valid[h] = 1'b0;
				tbl_valid[pg] = 1'b1;
				tbl_frame[pg] = tbl_frame[h];
				tbl_use[pg] = 1'b1;
			end
			clock_hand = (h + 1 >= count) ? 0 : h + 1;
			if (victim)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic xlate_t lookup_page(table_word_t w);
		xlate_t r;
		logic [15:0] pg;
		logic [15:0] off;
		logic [31:0] wide;
		int unsigned count;
		r.status = ptcr_pkg::ST_LOADED;
		r.phys = '0;
		if (w.op == OP_LOAD) begin
			tbl_valid[w.idx] = w.v;
			tbl_perm[w.idx] = w.p;
			tbl_frame[w.idx] = w.f;
			tbl_use[w.idx] = w.u;
		end else begin
			pg = w.addr >> offset_bits;
			off = w.addr & ((16'd1 << offset_bits) - 16'd1);
			count = page_count();
			if (pg >= count) begin
				r.status = ptcr_pkg::ST_RANGE;
			end else if (tbl_valid[pg]) begin
				tbl_use[pg] = 1'b1;
				r.status = ptcr_pkg::ST_HIT;
			end else if (tbl_perm[pg]) begin
				r.status = clock_evict(pg, count) ? ptcr_pkg::ST_FAULT : ptcr_pkg::ST_NOVICTIM;
			end else begin
				r.status = ptcr_pkg::ST_SEGV;
			end
			if (r.status == ptcr_pkg::ST_HIT || r.status == ptcr_pkg::ST_FAULT) begin
				wide = ({16'd0, tbl_frame[pg]} << offset_bits) | {16'd0, off};
				r.phys = wide[30:0];
			end
		end
		return r;
	endfunction

	function automatic table_word_t load_word(logic [7:0] idx, logic v, logic p,
			logic [15:0] f, logic u);
		table_word_t w;
		w = '{OP_LOAD, idx, 16'd0, v, p, f, u};
		return w;
	endfunction

	function automatic table_word_t xlate_word(logic [15:0] addr);
		table_word_t w;
		w = '{OP_XLATE, 8'd0, addr, 1'b0, 1'b0, 16'd0, 1'b0};
		return w;
	endfunction

	function automatic table_word_t random_word();
		table_word_t w;
		int unsigned count;
		int unsigned pg;
		count = page_count();
		w.op = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_XLATE;
		w.idx = 8'($urandom_range(0, 255));
		w.addr = 16'($urandom_range(0, 65535));
		w.v = 1'($urandom_range(0, 1));
		w.p = ($urandom_range(0, 99) < 75);
		w.f = 16'($urandom_range(0, 65535));
		w.u = 1'($urandom_range(0, 1));
		if (count != 0 && $urandom_range(0, 9) < 8) begin
			pg = $urandom_range(0, count - 1);
			w.idx = 8'(pg);
			w.addr = 16'((pg << offset_bits) | (w.addr & ((1 << offset_bits) - 1)));
		end
		return w;
	endfunction

	task automatic send_word(input table_word_t w);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.op;
		page_index <= w.idx;
		virt_addr <= w.addr;
		entry_valid <= w.v;
		entry_perm <= w.p;
		entry_frame <= w.f;
		entry_use <= w.u;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		pending_results.push_back(lookup_page(w));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_geometry(input logic [3:0] ob, input logic [4:0] vab);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= ptcr_pkg::REG_PAGE_OFFSET_BITS;
		cfg_data <= {1'b0, ob};
		@(posedge clk);
		cfg_index <= ptcr_pkg::REG_VIRT_ADDR_BITS;
		cfg_data <= vab;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_bits = ob;
		vaddr_bits = vab;
	endtask

	always @(negedge clk) begin
		xlate_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d phys_addr %h", status, phys_addr);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || phys_addr !== want.phys) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0d got %0d, phys_addr exp %h got %h",
							want.status, status, want.phys, phys_addr);
				end
			end
		end
	end

	task automatic test_hit_and_fault();
		set_geometry(4'd8, 5'd16);
		send_word(xlate_word(16'h0000));
		send_word(load_word(8'd0, 1'b1, 1'b1, 16'hFFFF, 1'b0));
		send_word(xlate_word(16'h00FF));
		send_word(load_word(8'd255, 1'b0, 1'b1, 16'h0000, 1'b0));
		send_word(xlate_word(16'hFFAB));
		send_word(load_word(8'd200, 1'b1, 1'b0, 16'h1234, 1'b0));
		send_word(load_word(8'd201, 1'b0, 1'b1, 16'h0000, 1'b1));
		send_word(xlate_word(16'hC900));
	endtask

	task automatic test_no_victim_and_hand_wrap();
		set_geometry(4'd8, 5'd10);
		send_word(load_word(8'd0, 1'b1, 1'b1, 16'h00AA, 1'b0));
		send_word(load_word(8'd3, 1'b0, 1'b1, 16'h0000, 1'b0));
		send_word(xlate_word(16'h037F));
		for (int i = 0; i < 4; i++)
			send_word(load_word(8'(i), 1'b0, (i != 1), 16'h0000, 1'b0));
		send_word(xlate_word(16'h0210));
		send_word(xlate_word(16'h0400));
	endtask

	task automatic test_offset_extremes();
		set_geometry(4'd15, 5'd3);
		send_word(xlate_word(16'h0000));
		send_word(xlate_word(16'hFFFF));
		set_geometry(4'd0, 5'd16);
		send_word(load_word(8'd5, 1'b1, 1'b1, 16'hFFFF, 1'b1));
		send_word(xlate_word(16'h0005));
		send_word(xlate_word(16'h0100));
		set_geometry(4'd15, 5'd31);
		send_word(load_word(8'd1, 1'b1, 1'b0, 16'hFFFF, 1'b0));
		send_word(xlate_word(16'hFFFF));
		send_word(xlate_word(16'h7FFF));
	endtask

	task automatic test_random_traffic(input int snd, input int rcv);
		logic [3:0] ob;
		logic [4:0] vab;
		int pick;
		send_idle = snd;
		recv_idle = rcv;
		for (int s = 0; s < SEGMENTS; s++) begin
			ob = 4'($urandom_range(0, 15));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				vab = (ob == 0) ? 5'd0 : 5'($urandom_range(0, ob - 1));
			else if (pick == 1)
				vab = 5'($urandom_range(ob + 8, 31));
			else
				vab = 5'(ob + $urandom_range(0, 3));
			set_geometry(ob, vab);
			for (int i = 0; i < WORDS_PER_SEGMENT; i++)
				send_word(random_word());
		end
	endtask

	initial begin
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_perm[i] = 1'b0;
			tbl_frame[i] = 16'd0;
			tbl_use[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hit_and_fault();
		test_no_victim_and_hand_wrap();
		test_offset_extremes();
		test_random_traffic(34, 60);
		test_random_traffic(60, 34);
		test_random_traffic(0, 0);
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
